// ===== hdl/grtg_pkg.sv =====
// shared types and codes for the gray-ramp gamma table block
package grtg_pkg;

	// request opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_ENTRY  = 2'd0;
	localparam logic [1:0] ST_ACK    = 2'd1;
	localparam logic [1:0] ST_NORAMP = 2'd2;
	localparam logic [1:0] ST_ZSPAN  = 2'd3;

	// sample and table widths
	localparam int SAMPLE_W = 20;
	localparam int IDEAL_W  = 18;
	localparam int MIR_W    = 22;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 8;
	localparam int IDEAL_SH = 17;

	// per-lane control strobes from the sequencer
	typedef struct packed {
		logic we;
		logic clr;
		logic fin_acc;
		logic fin_first;
		logic fin_done;
		logic lat_a;
		logic lat_b;
		logic mul;
		logic sum;
		logic div_start;
	} grtg_lane_ctl_t;

endpackage

// ===== hdl/grtg_div.sv =====
// restoring divider, one quotient bit per cycle
module grtg_div import grtg_pkg::*; #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/grtg_lane.sv =====
// one color channel: sample memory, floor and span search, entry interpolation
module grtg_lane import grtg_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int OUT_SIZE    = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grtg_lane_ctl_t             ctl,
	input  logic [$clog2(MAX_SAMPLES)-1:0] wr_addr,
	input  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	input  logic [IDEAL_W-1:0]         ideal,
	input  logic [$clog2(OUT_SIZE)-1:0] frac,
	output logic                       span_zero,
	output logic                       done,
	output logic [VALUE_W-1:0]         value
);

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int DW  = $clog2(OUT_SIZE);
	localparam int DEN = OUT_SIZE - 1;
	localparam int PW  = MIR_W + DW;
	localparam int LNW = PW + 1 + VALUE_W;
	localparam int LDW = PW;

	logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic signed [SAMPLE_W-1:0] rdata_q;
	logic signed [MIR_W-1:0]    lo_q;
	logic signed [MIR_W-1:0]    hi_q;
	logic signed [MIR_W-1:0]    floor_q;
	logic [MIR_W-1:0]           span_q;
	logic [MIR_W-1:0]           a_q;
	logic [MIR_W-1:0]           b_q;
	logic [PW-1:0]              pa_s1;
	logic [PW-1:0]              pb_s1;
	logic [LDW-1:0]             dsp_s1;
	logic [PW:0]                acc_s2;
	logic signed [MIR_W-1:0]    mir;
	logic [MIR_W-1:0]           rel;
	logic [LNW-1:0]             dnum;
	logic [LNW-1:0]             dquo;
	logic [LDW-1:0]             drem;

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.we)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// mirrored value and its offset above the floor
	always_comb begin
		mir = $signed({{(MIR_W-IDEAL_W){1'b0}}, ideal})
			- {{(MIR_W-SAMPLE_W){rdata_q[SAMPLE_W-1]}}, rdata_q};
		rel = MIR_W'(mir - floor_q);
	end

	// floor and span search over the ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= '0;
			floor_q <= '0;
			span_q  <= '0;
		end else if (ctl.clr) begin
			lo_q    <= '0;
			hi_q    <= '0;
			floor_q <= '0;
			span_q  <= '0;
		end else if (ctl.fin_acc) begin
			if (ctl.fin_first || mir < lo_q)
				lo_q <= mir;
			if (ctl.fin_first || mir > hi_q)
				hi_q <= mir;
		end else if (ctl.fin_done) begin
			floor_q <= lo_q;
			span_q  <= MIR_W'(hi_q - lo_q);
		end
	end

	// interpolation datapath; upper neighbour unused when the position is exact
	always_ff @(posedge clk) begin
		if (ctl.lat_a)
			a_q <= rel;
		if (ctl.lat_b)
			b_q <= (frac == '0) ? '0 : rel;
		if (ctl.mul) begin
			pa_s1  <= PW'(a_q) * PW'(DW'(DEN) - frac);
			pb_s1  <= PW'(b_q) * PW'(frac);
			dsp_s1 <= LDW'(span_q) * LDW'(DEN);
		end
		if (ctl.sum)
			acc_s2 <= {1'b0, pa_s1} + {1'b0, pb_s1};
	end

	// scale by full scale: acc * 0xffff
	assign dnum = (LNW'(acc_s2) << VALUE_W) - LNW'(acc_s2);

	grtg_div #(.NW(LNW), .DW(LDW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (dnum),
		.den    (dsp_s1),
		.done   (done),
		.quo    (dquo),
		.rem    (drem)
	);

	assign span_zero = (span_q == '0);
	assign value     = (dquo > LNW'(16'hffff)) ? 16'hffff : dquo[VALUE_W-1:0];

endmodule

// ===== hdl/gray_ramp_to_gamma_table_core.sv =====
// gray-ramp to gamma table: sequencer, three channel lanes and result merge
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata: opcode, red, green, blue, entry_index; tlast
// m_*      out  tvalid/tready      tdata: status, red_out, green_out, blue_out
//
// load, clear, unused opcodes and refused reads go straight to the result; a last load
// walks each stored sample (read, then accumulate) and then the floor/span step, and with
// two or more samples runs the step divide ahead of the walk.
// a read runs two ideal-value divides on the scalar divider, then the lane dividers;
// the position uses a reciprocal multiply.
// reset clears counts, ready flag, floors and spans; sample memory is not cleared.
// one transaction is in work at a time; the output register lets a new one be
// taken while the previous result waits for m_tready.
module gray_ramp_to_gamma_table_core import grtg_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int OUT_SIZE    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // opcode, red_sample, green_sample, blue_sample, entry_index
	input  logic        s_tlast,  // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status, red_out, green_out, blue_out
);

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int DW    = $clog2(OUT_SIZE);
	localparam int DEN   = OUT_SIZE - 1;
	localparam int SNW   = CW + IDEAL_SH + 1;
	localparam int SDW   = (CW > DW) ? CW : DW;
	localparam int PNW   = INDEX_W + CW;
	localparam int RSH   = PNW + DW;
	localparam int RCP_W = PNW + 2;
	localparam int RPW   = PNW + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((longint'(1) << RSH) + longint'(DEN) - 1) / longint'(DEN));

	typedef enum logic [3:0] {
		S_IDLE, S_FQ, S_FRD, S_FACC, S_FIN, S_RF, S_IA, S_IB,
		S_MUL, S_SUM, S_LDIV, S_LWAIT, S_OUT
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic                 ready_q;
	logic [CW-1:0]        k_q;
	logic [IDEAL_W-1:0]   ideal_q;
	logic [CW-1:0]        irem_q;
	logic [IDEAL_W-1:0]   q0_q;
	logic [CW-1:0]        r0_q;
	logic [CW-1:0]        r_q;
	logic [DW-1:0]        f_q;
	logic [PNW-1:0]       pnum_q;
	logic [1:0]           res_status_q;
	logic [VALUE_W-1:0]   res_red_q;
	logic [VALUE_W-1:0]   res_green_q;
	logic [VALUE_W-1:0]   res_blue_q;
	logic                 m_tvalid_q;
	logic [55:0]          m_tdata_q;

	logic [1:0]           opcode;
	logic [SAMPLE_W-1:0]  in_red;
	logic [SAMPLE_W-1:0]  in_green;
	logic [SAMPLE_W-1:0]  in_blue;
	logic [INDEX_W-1:0]   entry_index;
	logic                 accept;
	logic [CW-1:0]        cnt_base;
	logic                 room;
	logic [CW-1:0]        n_new;
	logic [INDEX_W-1:0]   idx_sat;
	logic [CW:0]          irem_sum;
	logic [RPW-1:0]       rprod;
	logic [CW-1:0]        r_calc;
	logic                 sstart;
	logic [SNW-1:0]       snum;
	logic [SDW-1:0]       sden;
	logic                 sdone;
	logic [SNW-1:0]       squo;
	logic [SDW-1:0]       srem;
	grtg_lane_ctl_t       lctl;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [IDEAL_W-1:0]   lane_ideal;
	logic [2:0]           span_zero;
	logic [2:0]           lane_done;
	logic [VALUE_W-1:0]   lane_val [3];

	// input unpacking
	assign opcode      = s_tdata[1:0];
	assign in_red      = s_tdata[21:2];
	assign in_green    = s_tdata[41:22];
	assign in_blue     = s_tdata[61:42];
	assign entry_index = s_tdata[69:62];
	assign s_tready    = (state_q == S_IDLE);
	assign accept      = s_tvalid && s_tready;

	// load address, new count, read index saturation and table position
	always_comb begin
		cnt_base = ready_q ? '0 : count_q;
		room     = (32'(cnt_base) < MAX_SAMPLES);
		n_new    = room ? cnt_base + 1'b1 : cnt_base;
		idx_sat  = (32'(entry_index) > DEN) ? INDEX_W'(DEN) : entry_index;
		irem_sum = {1'b0, irem_q} + {1'b0, r0_q};
		rprod    = RPW'(pnum_q) * RPW'(RCP);
		r_calc   = CW'(rprod >> RSH);
	end

	// scalar divider requests
	always_comb begin
		sstart = 1'b0;
		snum   = '0;
		sden   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_LOAD && s_tlast && n_new >= CW'(2)) begin
					sstart = 1'b1;
					snum   = SNW'(1) << IDEAL_SH;
					sden   = SDW'(n_new - 1'b1);
				end
			end
			S_RF: begin
				sstart = 1'b1;
				snum   = SNW'(r_calc) << IDEAL_SH;
				sden   = SDW'(count_q - 1'b1);
			end
			S_IA: begin
				sstart = sdone;
				snum   = SNW'(r_q + 1'b1) << IDEAL_SH;
				sden   = SDW'(count_q - 1'b1);
			end
			default: begin
				sstart = 1'b0;
			end
		endcase
	end

	grtg_div #(.NW(SNW), .DW(SDW)) u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sstart),
		.num    (snum),
		.den    (sden),
		.done   (sdone),
		.quo    (squo),
		.rem    (srem)
	);

	// lane strobes and shared lane inputs
	always_comb begin
		lctl           = '0;
		lctl.we        = accept && opcode == OP_LOAD && room;
		lctl.clr       = accept && opcode == OP_CLEAR;
		lctl.fin_acc   = (state_q == S_FACC);
		lctl.fin_first = (k_q == '0);
		lctl.fin_done  = (state_q == S_FIN);
		lctl.lat_a     = (state_q == S_IA) && sdone;
		lctl.lat_b     = (state_q == S_IB) && sdone;
		lctl.mul       = (state_q == S_MUL);
		lctl.sum       = (state_q == S_SUM);
		lctl.div_start = (state_q == S_LDIV);
		wr_addr        = cnt_base[AW-1:0];
		unique case (state_q)
			S_FRD, S_FACC: rd_addr = k_q[AW-1:0];
			S_IB:          rd_addr = AW'(r_q + 1'b1);
			default:       rd_addr = r_q[AW-1:0];
		endcase
		lane_ideal = (state_q == S_FACC) ? ideal_q : squo[IDEAL_W-1:0];
	end

	// channel lanes
	grtg_lane #(.MAX_SAMPLES(MAX_SAMPLES), .OUT_SIZE(OUT_SIZE)) u_lane_r (
		.clk (clk), .arst_n (arst_n), .ctl (lctl), .wr_addr (wr_addr),
		.rd_addr (rd_addr), .wr_data (in_red), .ideal (lane_ideal), .frac (f_q),
		.span_zero (span_zero[0]), .done (lane_done[0]), .value (lane_val[0])
	);

	grtg_lane #(.MAX_SAMPLES(MAX_SAMPLES), .OUT_SIZE(OUT_SIZE)) u_lane_g (
		.clk (clk), .arst_n (arst_n), .ctl (lctl), .wr_addr (wr_addr),
		.rd_addr (rd_addr), .wr_data (in_green), .ideal (lane_ideal), .frac (f_q),
		.span_zero (span_zero[1]), .done (lane_done[1]), .value (lane_val[1])
	);

	grtg_lane #(.MAX_SAMPLES(MAX_SAMPLES), .OUT_SIZE(OUT_SIZE)) u_lane_b (
		.clk (clk), .arst_n (arst_n), .ctl (lctl), .wr_addr (wr_addr),
		.rd_addr (rd_addr), .wr_data (in_blue), .ideal (lane_ideal), .frac (f_q),
		.span_zero (span_zero[2]), .done (lane_done[2]), .value (lane_val[2])
	);

	// sequencer, ramp state and merged result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ready_q      <= 1'b0;
			k_q          <= '0;
			ideal_q      <= '0;
			irem_q       <= '0;
			q0_q         <= '0;
			r0_q         <= '0;
			r_q          <= '0;
			f_q          <= '0;
			pnum_q       <= '0;
			res_status_q <= ST_ACK;
			res_red_q    <= '0;
			res_green_q  <= '0;
			res_blue_q   <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_red_q   <= '0;
						res_green_q <= '0;
						res_blue_q  <= '0;
						unique case (opcode)
							OP_LOAD: begin
								res_status_q <= ST_ACK;
								count_q      <= n_new;
								ready_q      <= 1'b0;
								if (s_tlast) begin
									k_q     <= '0;
									ideal_q <= '0;
									irem_q  <= '0;
									if (n_new >= CW'(2)) begin
										state_q <= S_FQ;
									end else begin
										q0_q    <= '0;
										r0_q    <= '0;
										state_q <= S_FRD;
									end
								end else begin
									state_q <= S_OUT;
								end
							end
							OP_READ: begin
								if (!ready_q) begin
									res_status_q <= ST_NORAMP;
									state_q      <= S_OUT;
								end else if (span_zero != '0) begin
									res_status_q <= ST_ZSPAN;
									state_q      <= S_OUT;
								end else begin
									pnum_q  <= PNW'(idx_sat) * PNW'(count_q - 1'b1);
									state_q <= S_RF;
								end
							end
							OP_CLEAR: begin
								res_status_q <= ST_ACK;
								count_q      <= '0;
								ready_q      <= 1'b0;
								state_q      <= S_OUT;
							end
							default: begin
								res_status_q <= ST_ACK;
								state_q      <= S_OUT;
							end
						endcase
					end
				end
				S_FQ: begin
					if (sdone) begin
						q0_q    <= squo[IDEAL_W-1:0];
						r0_q    <= srem[CW-1:0];
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FACC;
				end
				S_FACC: begin
					// next ideal value by quotient and remainder steps
					if (irem_sum >= {1'b0, count_q - 1'b1} && count_q >= CW'(2)) begin
						irem_q  <= CW'(irem_sum - {1'b0, count_q - 1'b1});
						ideal_q <= ideal_q + q0_q + 1'b1;
					end else begin
						irem_q  <= irem_sum[CW-1:0];
						ideal_q <= ideal_q + q0_q;
					end
					k_q <= k_q + 1'b1;
					if (k_q == count_q - 1'b1)
						state_q <= S_FIN;
					else
						state_q <= S_FRD;
				end
				S_FIN: begin
					ready_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_RF: begin
					// whole part of the position; the divide for its ideal value starts here
					r_q     <= r_calc;
					state_q <= S_IA;
				end
				S_IA: begin
					f_q <= DW'(pnum_q - PNW'(r_q) * PNW'(DEN));
					if (sdone)
						state_q <= S_IB;
				end
				S_IB: begin
					if (sdone)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_LDIV;
				end
				S_LDIV: begin
					state_q <= S_LWAIT;
				end
				S_LWAIT: begin
					if (&lane_done) begin
						res_status_q <= ST_ENTRY;
						res_red_q    <= lane_val[0];
						res_green_q  <= lane_val[1];
						res_blue_q   <= lane_val[2];
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, res_blue_q, res_green_q, res_red_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== dv/gamma_table_checker.sv =====
// gamma table checker: predicts each result from the input channel and compares it
`timescale 1ns / 100ps

module gamma_table_checker import grtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,  // opcode, red, green, blue, entry_index
	input  logic        s_tlast,  // last_sample
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // status, red_out, green_out, blue_out
	output int          fail_count,
	output int          pending
);

	localparam int RAMP_DEPTH = 64;
	localparam longint TABLE_DEN = 255;
	localparam longint FULL_SCALE = 65535;

	// laid out as on m_tdata, status in the lowest bits
	typedef struct packed {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
		logic [1:0]  status;
	} table_result_t;

	// predicted block state
	logic signed [19:0] ramp_samp [RAMP_DEPTH][3];
	int                 n_loaded;
	bit                 ramp_done;
	longint             ch_floor [3];
	longint             ch_span [3];

	table_result_t      result_q [$];

	// ideal ramp minus the measured sample
	function automatic longint mirror_val(int k, int ch);
		longint ideal;
		ideal = 0;
		if (n_loaded >= 2)
			ideal = (longint'(k) * 131072) / longint'(n_loaded - 1);
		return ideal - longint'(ramp_samp[k][ch]);
	endfunction

	// floor and span walk over the stored ramp
	function automatic void close_ramp();
		longint lo, hi, m;
		for (int ch = 0; ch < 3; ch++) begin
			lo = 0;
			hi = 0;
			for (int k = 0; k < n_loaded; k++) begin
				m = mirror_val(k, ch);
				if (k == 0 || m < lo) lo = m;
				if (k == 0 || m > hi) hi = m;
			end
			ch_floor[ch] = lo;
			ch_span[ch] = (hi - lo) & 64'h3fffff;
		end
		ramp_done = 1'b1;
	endfunction

	// apply one transaction to the state and return the table result it causes
	function automatic table_result_t table_lookup(logic [71:0] d, logic last);
		table_result_t res;
		logic [1:0]    op;
		logic [7:0]    idx;
		longint        num, r, f, a, b, acc, v;
		longint        vals [3];
		op = d[1:0];
		idx = d[69:62];
		res = '0;
		res.status = ST_ACK;
		if (op == OP_LOAD) begin
			if (ramp_done) begin
				ramp_done = 1'b0;
				n_loaded = 0;
			end
			if (n_loaded < RAMP_DEPTH) begin
				ramp_samp[n_loaded][0] = d[21:2];
				ramp_samp[n_loaded][1] = d[41:22];
				ramp_samp[n_loaded][2] = d[61:42];
				n_loaded++;
			end
			if (last) close_ramp();
		end else if (op == OP_READ) begin
			if (!ramp_done || n_loaded == 0) begin
				res.status = ST_NORAMP;
				return res;
			end
			if (ch_span[0] == 0 || ch_span[1] == 0 || ch_span[2] == 0) begin
				res.status = ST_ZSPAN;
				return res;
			end
			num = longint'(idx) * longint'(n_loaded - 1);
			r = num / TABLE_DEN;
			f = num % TABLE_DEN;
			if (r > n_loaded - 1) r = n_loaded - 1;
			if (r == n_loaded - 1) f = 0;
			for (int ch = 0; ch < 3; ch++) begin
				a = mirror_val(int'(r), ch) - ch_floor[ch];
				if (f == 0) begin
					acc = a * TABLE_DEN;
				end else begin
					b = mirror_val(int'(r) + 1, ch) - ch_floor[ch];
					acc = a * (TABLE_DEN - f) + b * f;
				end
				v = (acc * FULL_SCALE) / (TABLE_DEN * ch_span[ch]);
				if (v > FULL_SCALE) v = FULL_SCALE;
				vals[ch] = v;
			end
			res.status = ST_ENTRY;
			res.red = vals[0][15:0];
			res.green = vals[1][15:0];
			res.blue = vals[2][15:0];
		end else if (op == OP_CLEAR) begin
			n_loaded = 0;
			ramp_done = 1'b0;
			for (int ch = 0; ch < 3; ch++) begin
				ch_floor[ch] = 0;
				ch_span[ch] = 0;
			end
		end
		return res;
	endfunction

	initial begin
		fail_count = 0;
		n_loaded = 0;
		ramp_done = 1'b0;
		for (int ch = 0; ch < 3; ch++) begin
			ch_floor[ch] = 0;
			ch_span[ch] = 0;
		end
	end

	assign pending = result_q.size();

	// predict on each input transaction, compare on each output transaction
	always @(posedge clk) begin
		table_result_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				result_q.push_back(table_lookup(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				got = m_tdata[49:0];
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = result_q.pop_front();
					if (got !== want || m_tdata[55:50] !== '0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: status %0d/%0d red %h/%h green %h/%h blue %h/%h (exp/act)",
								want.status, got.status, want.red, got.red,
								want.green, got.green, want.blue, got.blue);
					end
				end
			end
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the gray-ramp gamma table: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_top import grtg_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // opcode, red, green, blue, entry_index
	logic        s_tlast;  // last_sample
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // status, red_out, green_out, blue_out
	int          fail_count;
	int          pending;

	int          send_idle_pct;
	int          recv_stall_pct;
	int          sent_items;

	gray_ramp_to_gamma_table_core i_dut (.*);

	gamma_table_checker i_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, with one long hold-off to back the block up
	initial begin
		int cyc;
		int hold;
		cyc = 0;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 3000) hold = 2500;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one transaction, with random idle cycles first
	task automatic send_item(logic [1:0] op, logic [19:0] r, logic [19:0] g,
			logic [19:0] b, logic last, logic [7:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, idx, b, g, r, op};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic load_sample(logic [19:0] r, logic [19:0] g, logic [19:0] b, logic last);
		send_item(OP_LOAD, r, g, b, last, $urandom);
	endtask

	task automatic read_entry(logic [7:0] idx);
		send_item(OP_READ, $urandom, $urandom, $urandom, $urandom, idx);
	endtask

	// well-formed ramp followed by some reads, or a stray transaction
	task automatic random_sequence();
		int n;
		if ($urandom_range(99) < 85) begin
			if ($urandom_range(99) < 20)
				send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
			n = ($urandom_range(99) < 4) ? $urandom_range(70, 60) : $urandom_range(8, 1);
			for (int k = 0; k < n; k++)
				load_sample($urandom, $urandom, $urandom, k == n - 1);
			n = $urandom_range(6, 1);
			for (int k = 0; k < n; k++)
				read_entry($urandom);
		end else begin
			send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent_items = 0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: no ramp, unused opcode, zero spans, extremes
		read_entry(8'd0);
		send_item(2'd3, 20'hfffff, 20'hfffff, 20'hfffff, 1'b1, 8'hff);
		load_sample(20'd0, 20'd0, 20'd0, 1'b1);
		read_entry(8'd255);
		load_sample(20'd0, 20'd0, 20'd0, 1'b0);
		load_sample(20'd131072, 20'd131072, 20'd131072, 1'b1);
		read_entry(8'd7);
		send_item(OP_CLEAR, 20'hfffff, 20'hfffff, 20'hfffff, 1'b1, 8'hff);
		read_entry(8'd100);
		load_sample(20'h80000, 20'h7ffff, 20'd0, 1'b0);
		load_sample(20'h7ffff, 20'h80000, 20'd12345, 1'b0);
		load_sample(20'd0, 20'd0, 20'h80000, 1'b1);
		read_entry(8'd0);
		read_entry(8'd127);
		read_entry(8'd128);
		read_entry(8'd255);
		read_entry(8'd1);
		// load after a finished ramp starts a new one
		load_sample(20'd1, 20'hfffff, 20'd5, 1'b0);
		read_entry(8'd3);
		load_sample(20'd99, 20'd7, 20'h40000, 1'b1);
		read_entry(8'd200);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 17 : 0;
			recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 17 : 0;
			while (sent_items < 20 + 325 * (ph + 1))
				random_sequence();
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/grtg_pkg.sv
hdl/grtg_div.sv
hdl/grtg_lane.sv
hdl/gray_ramp_to_gamma_table_core.sv
dv/gamma_table_checker.sv
dv/tb_top.sv
